@@ hw/rtl/puff_event_counter_macros.svh @@
// Assertion macros used by the puff event counter core.
`ifndef PUFF_EVENT_COUNTER_MACROS_SVH
`define PUFF_EVENT_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEC_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("puff_event_counter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PEC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("puff_event_counter: next-cycle check failed");

`endif

@@ hw/rtl/pec_pkg.sv @@
package pec_pkg;

	// Request and result payloads.
	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] temp_centi;
		logic [15:0] power_mw;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [5:0]         puffs_left;
		logic signed [19:0] slope_x200;
		logic [1:0]         detect_phase;
		logic [2:0]         puffs_taken;
	} result_t;

	// Configuration register set.
	typedef struct packed {
		logic [11:0]        start_slope;
		logic [11:0]        confirm_slope;
		logic signed [12:0] fall_slope;
		logic [15:0]        power_high_mw;
		logic [15:0]        warmup_end_ms;
		logic [15:0]        long_puff_after_ms;
		logic [15:0]        warm_drop_centi;
		logic [5:0]         session_puffs;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CONFIRM = 2'd1,
		PH_FALL    = 2'd2
	} phase_t;

	// Request function codes.
	localparam logic [1:0] FUNC_TEMP    = 2'd0;
	localparam logic [1:0] FUNC_POWER   = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SLOPE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SLOPE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_SLOPE    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_HIGH    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_END    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PUFF     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WARM_DROP     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SESSION_PUFFS = 4'd7;

	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [11:0]        START_SLOPE_RST   = 12'd70;
	localparam logic [11:0]        CONFIRM_SLOPE_RST = 12'd84;
	localparam logic signed [12:0] FALL_SLOPE_RST    = -13'sd10;
	localparam logic [15:0]        POWER_HIGH_RST    = 16'd3000;
	localparam logic [15:0]        WARMUP_END_RST    = 16'd10000;
	localparam logic [15:0]        LONG_PUFF_RST     = 16'd25000;
	localparam logic [15:0]        WARM_DROP_RST     = 16'd800;
	localparam logic [5:0]         SESSION_PUFFS_RST = 6'd15;

	// Fixed timing constants.
	localparam logic [31:0] EARLY_PUFF_AFTER_MS  = 32'd6000;
	localparam logic [31:0] POWER_WATCH_AFTER_MS = 32'd5000;
	localparam logic [3:0]  TIMER_MAX            = 4'd15;

	// High-power stretch lengths, in ticks, that take one to five puffs.
	localparam int unsigned TICKS_FOR_1 = 175;
	localparam int unsigned TICKS_FOR_2 = 650;
	localparam int unsigned TICKS_FOR_3 = 1050;
	localparam int unsigned TICKS_FOR_4 = 1400;
	localparam int unsigned TICKS_FOR_5 = 1750;

	// Warm-up reference curve: breakpoints in ms and temperatures in 0.01 C.
	localparam int CURVE_T [5] = '{0, 7500, 9000, 21000, 60000};
	localparam int CURVE_V [5] = '{2500, 33500, 32500, 23500, 22000};
	// Segment start value times segment length.
	localparam int CURVE_BASE [4] = '{
		CURVE_V[0] * (CURVE_T[1] - CURVE_T[0]),
		CURVE_V[1] * (CURVE_T[2] - CURVE_T[1]),
		CURVE_V[2] * (CURVE_T[3] - CURVE_T[2]),
		CURVE_V[3] * (CURVE_T[4] - CURVE_T[3])
	};

	// Count after removing n puffs, stopping at zero.
	function automatic logic [5:0] take_puffs(input logic [5:0] count, input logic [2:0] n);
		logic [5:0] n6;
		n6 = {3'b000, n};
		return (count >= n6) ? count - n6 : 6'd0;
	endfunction

endpackage

@@ hw/rtl/pec_cfg.sv @@
module pec_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [pec_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [pec_pkg::CFG_DATA_W-1:0]        wr_data,
	output pec_pkg::cfg_t                         cfg
);

	pec_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_slope        <= pec_pkg::START_SLOPE_RST;
			cfg_q.confirm_slope      <= pec_pkg::CONFIRM_SLOPE_RST;
			cfg_q.fall_slope         <= pec_pkg::FALL_SLOPE_RST;
			cfg_q.power_high_mw      <= pec_pkg::POWER_HIGH_RST;
			cfg_q.warmup_end_ms      <= pec_pkg::WARMUP_END_RST;
			cfg_q.long_puff_after_ms <= pec_pkg::LONG_PUFF_RST;
			cfg_q.warm_drop_centi    <= pec_pkg::WARM_DROP_RST;
			cfg_q.session_puffs      <= pec_pkg::SESSION_PUFFS_RST;
		end else if (wr_en) begin
			case (wr_index)
				pec_pkg::CFG_START_SLOPE:   cfg_q.start_slope        <= wr_data[11:0];
				pec_pkg::CFG_CONFIRM_SLOPE: cfg_q.confirm_slope      <= wr_data[11:0];
				pec_pkg::CFG_FALL_SLOPE:    cfg_q.fall_slope         <= $signed(wr_data[12:0]);
				pec_pkg::CFG_POWER_HIGH:    cfg_q.power_high_mw      <= wr_data;
				pec_pkg::CFG_WARMUP_END:    cfg_q.warmup_end_ms      <= wr_data;
				pec_pkg::CFG_LONG_PUFF:     cfg_q.long_puff_after_ms <= wr_data;
				pec_pkg::CFG_WARM_DROP:     cfg_q.warm_drop_centi    <= wr_data;
				pec_pkg::CFG_SESSION_PUFFS: cfg_q.session_puffs      <= wr_data[5:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/pec_curve.sv @@
module pec_curve (
	input  logic [15:0] temp_centi,
	input  logic [15:0] drop_centi,
	input  logic [15:0] time_lo,
	output logic        below
);

	// The curve test is only used while time is within the 16-bit warm-up window.
	logic [1:0]         seg;
	logic [2:0]         idx;
	logic [2:0]         nxt;
	logic [15:0]        dt;
	logic [15:0]        t0;
	logic signed [15:0] dv;
	logic [29:0]        base;
	logic [15:0]        off;
	logic [16:0]        temp_sum;
	logic [32:0]        lhs;
	logic signed [32:0] step;
	logic signed [35:0] rhs;

	always_comb begin
		if (time_lo < 16'(pec_pkg::CURVE_T[1])) begin
			seg = 2'd0;
		end else if (time_lo < 16'(pec_pkg::CURVE_T[2])) begin
			seg = 2'd1;
		end else if (time_lo < 16'(pec_pkg::CURVE_T[3])) begin
			seg = 2'd2;
		end else begin
			seg = 2'd3;
		end
	end

	assign idx  = {1'b0, seg};
	assign nxt  = idx + 3'd1;
	assign dt   = 16'(pec_pkg::CURVE_T[nxt] - pec_pkg::CURVE_T[idx]);
	assign t0   = 16'(pec_pkg::CURVE_T[idx]);
	assign dv   = 16'(pec_pkg::CURVE_V[nxt] - pec_pkg::CURVE_V[idx]);
	assign base = 30'(pec_pkg::CURVE_BASE[seg]);
	assign off  = time_lo - t0;

	// Exact compare: (temp + drop) * dt < v0 * dt + dv * (t - t0).
	assign temp_sum = {1'b0, temp_centi} + {1'b0, drop_centi};
	assign lhs      = {16'b0, temp_sum} * {17'b0, dt};
	assign step     = $signed({{17{dv[15]}}, dv}) * $signed({17'b0, off});
	assign rhs      = $signed({6'b0, base}) + $signed({{3{step[32]}}, step});
	assign below    = $signed({3'b000, lhs}) < rhs;

endmodule

@@ hw/rtl/pec_core.sv @@
`include "puff_event_counter_macros.svh"

module pec_core #(
	parameter int CONFIRM_TIMEOUT = 2,
	parameter int FALL_TIMEOUT    = 10,
	parameter int TICK_BITS       = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  pec_pkg::sample_t item,
	input  pec_pkg::cfg_t    cfg,
	output pec_pkg::result_t res
);

	logic [15:0]          hist0_q, hist1_q;
	pec_pkg::phase_t      phase_q;
	logic [3:0]           timer_q;
	logic [5:0]           puff_count_q;
	logic [TICK_BITS-1:0] ticks_q;

	logic [15:0]          hist0_d, hist1_d;
	pec_pkg::phase_t      phase_d;
	logic [3:0]           timer_d;
	logic [5:0]           count_d;
	logic [TICK_BITS-1:0] ticks_d;

	logic signed [16:0] diff;
	logic signed [19:0] slope_raw;
	logic signed [19:0] slope;
	logic               detect_on;
	logic               below;
	logic               early_puff;
	logic [2:0]         tick_puffs;

	pec_curve u_curve (
		.temp_centi (item.temp_centi),
		.drop_centi (cfg.warm_drop_centi),
		.time_lo    (item.time_ms[15:0]),
		.below      (below)
	);

	assign diff      = $signed({1'b0, item.temp_centi}) - $signed({1'b0, hist1_q});
	assign slope_raw = ($signed({{3{diff[16]}}, diff}) <<< 2) + $signed({{3{diff[16]}}, diff});
	assign detect_on = (item.time_ms > {16'b0, cfg.warmup_end_ms})
		|| (puff_count_q < cfg.session_puffs);
	assign early_puff = (item.time_ms > pec_pkg::EARLY_PUFF_AFTER_MS) && below
		&& (puff_count_q >= cfg.session_puffs);

	always_comb begin
		if (ticks_q >= TICK_BITS'(pec_pkg::TICKS_FOR_5)) begin
			tick_puffs = 3'd5;
		end else if (ticks_q >= TICK_BITS'(pec_pkg::TICKS_FOR_4)) begin
			tick_puffs = 3'd4;
		end else if (ticks_q >= TICK_BITS'(pec_pkg::TICKS_FOR_3)) begin
			tick_puffs = 3'd3;
		end else if (ticks_q >= TICK_BITS'(pec_pkg::TICKS_FOR_2)) begin
			tick_puffs = 3'd2;
		end else if (ticks_q >= TICK_BITS'(pec_pkg::TICKS_FOR_1)) begin
			tick_puffs = 3'd1;
		end else begin
			tick_puffs = 3'd0;
		end
	end

	// Next state for the request currently at the head of the pipe.
	always_comb begin
		hist0_d = hist0_q;
		hist1_d = hist1_q;
		phase_d = phase_q;
		timer_d = timer_q;
		count_d = puff_count_q;
		ticks_d = ticks_q;
		slope   = '0;
		case (item.func)
			pec_pkg::FUNC_TEMP: begin
				if (detect_on) begin
					slope   = slope_raw;
					hist1_d = hist0_q;
					hist0_d = item.temp_centi;
					case (phase_q)
						pec_pkg::PH_IDLE: begin
							if (slope_raw > $signed({8'b0, cfg.start_slope})) begin
								phase_d = pec_pkg::PH_CONFIRM;
							end
							timer_d = '0;
						end
						pec_pkg::PH_CONFIRM: begin
							if (slope_raw > $signed({8'b0, cfg.confirm_slope})) begin
								phase_d = pec_pkg::PH_FALL;
								timer_d = '0;
							end else if (timer_q >= 4'(CONFIRM_TIMEOUT)) begin
								phase_d = pec_pkg::PH_IDLE;
							end else if (timer_q < pec_pkg::TIMER_MAX) begin
								timer_d = timer_q + 4'd1;
							end
						end
						pec_pkg::PH_FALL: begin
							if (slope_raw < $signed({{7{cfg.fall_slope[12]}}, cfg.fall_slope})) begin
								count_d = pec_pkg::take_puffs(puff_count_q, 3'd1);
								phase_d = pec_pkg::PH_IDLE;
							end else if (timer_q >= 4'(FALL_TIMEOUT)) begin
								if (item.time_ms > {16'b0, cfg.long_puff_after_ms}) begin
									count_d = pec_pkg::take_puffs(puff_count_q, 3'd1);
								end
								phase_d = pec_pkg::PH_IDLE;
							end else if (timer_q < pec_pkg::TIMER_MAX) begin
								timer_d = timer_q + 4'd1;
							end
						end
						default: begin
						end
					endcase
				end else begin
					// Warm-up sample: refill the history, phase untouched.
					hist0_d = item.temp_centi;
					hist1_d = item.temp_centi;
					if (early_puff) begin
						count_d = pec_pkg::take_puffs(puff_count_q, 3'd1);
					end
				end
			end
			pec_pkg::FUNC_POWER: begin
				if (item.time_ms > pec_pkg::POWER_WATCH_AFTER_MS) begin
					if (item.power_mw > cfg.power_high_mw) begin
						if (ticks_q != {TICK_BITS{1'b1}}) begin
							ticks_d = ticks_q + TICK_BITS'(1);
						end
					end else begin
						count_d = pec_pkg::take_puffs(puff_count_q, tick_puffs);
						ticks_d = '0;
					end
				end
			end
			pec_pkg::FUNC_RESTART: begin
				count_d = cfg.session_puffs;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q      <= '0;
			hist1_q      <= '0;
			phase_q      <= pec_pkg::PH_IDLE;
			timer_q      <= '0;
			puff_count_q <= pec_pkg::SESSION_PUFFS_RST;
			ticks_q      <= '0;
		end else if (fire) begin
			hist0_q      <= hist0_d;
			hist1_q      <= hist1_d;
			phase_q      <= phase_d;
			timer_q      <= timer_d;
			puff_count_q <= count_d;
			ticks_q      <= ticks_d;
		end
	end

	assign res.puffs_left   = count_d;
	assign res.slope_x200   = slope;
	assign res.detect_phase = phase_d;
	assign res.puffs_taken  = (puff_count_q > count_d) ? 3'(puff_count_q - count_d) : 3'd0;

	`PEC_ASSERT_NEXT(a_power_keeps_phase, clk, arst_n, fire && item.func == pec_pkg::FUNC_POWER, $stable(phase_q) && $stable(timer_q))
	`PEC_ASSERT_NOW(a_slope_only_temp, clk, arst_n, fire && res.slope_x200 != 20'sd0, item.func == pec_pkg::FUNC_TEMP)
	`PEC_ASSERT_NEXT(a_idle_holds_state, clk, arst_n, !fire, $stable(puff_count_q) && $stable(ticks_q))
	`PEC_ASSERT_NOW(a_taken_lowers_count, clk, arst_n, fire && res.puffs_taken != 3'd0, res.puffs_left < puff_count_q)

endmodule

@@ hw/rtl/puff_event_counter.sv @@
// An accepted request sits in the input register, then its outcome goes to the result register.
// One request per cycle while result_stall is low; the update is a single pass of compare logic.
// Input stage and output register hold two requests; stall rises only when both are full
// and the result is being held off.
// Reset (arst_n low, asynchronous): registers back to defaults, 15 puffs, history and timers zero.
// No clearing pass is needed after reset; requests are accepted on the first cycle.
module puff_event_counter #(
	parameter int CONFIRM_TIMEOUT = 2,
	parameter int FALL_TIMEOUT    = 10,
	parameter int TICK_BITS       = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  pec_pkg::sample_t                   sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output pec_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pec_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// The input register holds one request; the core evaluates it against the
	// current state in the same cycle and the outcome lands in the result register.
	pec_pkg::sample_t item_s1;
	logic             valid_s1;
	pec_pkg::result_t result_q;
	logic             result_valid_q;

	pec_pkg::cfg_t    cfg;
	pec_pkg::result_t core_res;

	logic accept;
	logic advance;

	// Configuration writes are always taken; software writes only while idle (not enforced by the block).
	assign cfg_ready = 1'b1;

	pec_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The head request moves on whenever the result register is empty or being drained.
	// The state update happens on the same edge, so the next request sees it at once.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	pec_core #(
		.CONFIRM_TIMEOUT (CONFIRM_TIMEOUT),
		.FALL_TIMEOUT    (FALL_TIMEOUT),
		.TICK_BITS       (TICK_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// Payload stage; it only loads when a request is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// A stalled result holds because advance needs the register empty or draining.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	// Block parameters, passed to the instance so the predictor agrees with it.
	localparam int CONFIRM_LIMIT = 2;
	localparam int FALL_LIMIT    = 10;
	localparam int TICK_W        = 16;

	localparam int IDX_W  = pec_pkg::CFG_IDX_W;
	localparam int DATA_W = pec_pkg::CFG_DATA_W;

	localparam logic [1:0]        FUNC_UNUSED = 2'd3;
	localparam logic [3:0]        TIMER_TOP   = 4'd15;
	localparam logic [TICK_W-1:0] TICK_TOP    = {TICK_W{1'b1}};
	localparam logic [31:0]       EARLY_MS    = 32'd6000;
	localparam logic [31:0]       WATCH_MS    = 32'd5000;

	// The long receiver hold-off and the watchdog limit, both in clock cycles.
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	pec_pkg::sample_t  sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pec_pkg::result_t  result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	puff_event_counter #(
		.CONFIRM_TIMEOUT(CONFIRM_LIMIT),
		.FALL_TIMEOUT(FALL_LIMIT),
		.TICK_BITS(TICK_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Requests waiting for the driver, and the results predicted for accepted ones.
	pec_pkg::sample_t samples_to_send[$];
	pec_pkg::result_t results_due[$];

	// Predictor state: register copy, temperature history, detector and counters.
	pec_pkg::cfg_t     regs;
	logic [15:0]       seen_temp [2];
	pec_pkg::phase_t   det_phase;
	logic [3:0]        det_timer;
	logic [5:0]        puffs_now;
	logic [TICK_W-1:0] hot_ticks;

	// Warm-up reference curve: breakpoints in ms and temperatures in 0.01 C.
	longint warm_t [5] = '{0, 7500, 9000, 21000, 60000};
	longint warm_v [5] = '{2500, 33500, 32500, 23500, 22000};

	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_at = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	// While set, neither side idles on its own.
	bit          steady = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic pec_pkg::cfg_t pack_settings(input logic [11:0] start,
			input logic [11:0] confirm,
			input logic signed [12:0] fall, input logic [15:0] power,
			input logic [15:0] warmup, input logic [15:0] long_after,
			input logic [15:0] drop, input logic [5:0] session);
		return {start, confirm, fall, power, warmup, long_after, drop, session};
	endfunction

	task automatic report(input string msg);
		fail_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	function automatic void drop_puffs(input int unsigned n);
		puffs_now = (puffs_now >= n) ? puffs_now - 6'(n) : 6'd0;
	endfunction

	// Exact comparison against the curve: both sides are scaled by the segment length.
	function automatic bit under_warm_curve(input logic [15:0] temp, input logic [31:0] ms);
		int     k;
		longint span, lhs, rhs;
		k = 3;
		for (int i = 2; i >= 0; i--) begin
			if (warm_t[i] <= longint'(ms) && warm_t[i + 1] > longint'(ms)) k = i;
		end
		span = warm_t[k + 1] - warm_t[k];
		lhs = (longint'(temp) + longint'(regs.warm_drop_centi)) * span;
		rhs = warm_v[k] * span + (warm_v[k + 1] - warm_v[k]) * (longint'(ms) - warm_t[k]);
		return lhs < rhs;
	endfunction

	// Advances the predictor by one request and returns the result it should produce.
	function automatic pec_pkg::result_t predict_sample(input pec_pkg::sample_t s);
		pec_pkg::result_t r;
		logic [5:0]       was;
		int               slope;
		int unsigned      cost;
		was = puffs_now;
		slope = 0;
		case (s.func)
			pec_pkg::FUNC_TEMP: begin
				if (s.time_ms > {16'd0, regs.warmup_end_ms} ||
						puffs_now < regs.session_puffs) begin
					slope = 5 * (int'(s.temp_centi) - int'(seen_temp[1]));
					seen_temp[1] = seen_temp[0];
					seen_temp[0] = s.temp_centi;
					case (det_phase)
						pec_pkg::PH_IDLE: begin
							if (slope > int'(regs.start_slope)) det_phase = pec_pkg::PH_CONFIRM;
							det_timer = 4'd0;
						end
						pec_pkg::PH_CONFIRM: begin
							if (slope > int'(regs.confirm_slope)) begin
								det_phase = pec_pkg::PH_FALL;
								det_timer = 4'd0;
							end else if (det_timer >= CONFIRM_LIMIT) begin
								det_phase = pec_pkg::PH_IDLE;
							end else if (det_timer < TIMER_TOP) begin
								det_timer = det_timer + 4'd1;
							end
						end
						pec_pkg::PH_FALL: begin
							if (slope < int'(regs.fall_slope)) begin
								drop_puffs(1);
								det_phase = pec_pkg::PH_IDLE;
							end else if (det_timer >= FALL_LIMIT) begin
								// A puff that outlasts the fall window still counts late in the session.
								if (s.time_ms > {16'd0, regs.long_puff_after_ms}) drop_puffs(1);
								det_phase = pec_pkg::PH_IDLE;
							end else if (det_timer < TIMER_TOP) begin
								det_timer = det_timer + 4'd1;
							end
						end
						default: ;
					endcase
				end else begin
					// Warm-up: the history is flattened and only the curve test applies.
					seen_temp[0] = s.temp_centi;
					seen_temp[1] = s.temp_centi;
					if (s.time_ms > EARLY_MS && under_warm_curve(s.temp_centi, s.time_ms) &&
							puffs_now >= regs.session_puffs)
						drop_puffs(1);
				end
			end
			pec_pkg::FUNC_POWER: begin
				if (s.time_ms > WATCH_MS) begin
					if (s.power_mw > regs.power_high_mw) begin
						if (hot_ticks < TICK_TOP) hot_ticks = hot_ticks + 1'b1;
					end else begin
						if (hot_ticks >= 1750) cost = 5;
						else if (hot_ticks >= 1400) cost = 4;
						else if (hot_ticks >= 1050) cost = 3;
						else if (hot_ticks >= 650) cost = 2;
						else if (hot_ticks >= 175) cost = 1;
						else cost = 0;
						drop_puffs(cost);
						hot_ticks = '0;
					end
				end
			end
			pec_pkg::FUNC_RESTART: puffs_now = regs.session_puffs;
			default: ;
		endcase
		r.puffs_left = puffs_now;
		r.slope_x200 = slope[19:0];
		r.detect_phase = det_phase;
		r.puffs_taken = (was > puffs_now) ? 3'(was - puffs_now) : 3'd0;
		return r;
	endfunction

	task automatic push_sample(input logic [1:0] f, input logic [15:0] temp,
			input logic [15:0] power, input logic [31:0] ms);
		samples_to_send.push_back({f, temp, power, ms});
		queued_count++;
	endtask

	function automatic logic [31:0] power_time();
		return $urandom_range(32'hFFFF_FFFF, int'(WATCH_MS) + 1);
	endfunction

	// A stretch of high-power samples closed by one low sample.
	task automatic push_power_stretch(input int unsigned len);
		logic [15:0] top;
		top = regs.power_high_mw;
		for (int unsigned i = 0; i < len; i++) begin
			push_sample(pec_pkg::FUNC_POWER, 16'($urandom),
				(top == 16'hFFFF) ? 16'($urandom) : 16'($urandom_range(int'(top) + 1, 65535)),
				power_time());
		end
		push_sample(pec_pkg::FUNC_POWER, 16'($urandom), 16'($urandom_range(0, int'(top))),
			power_time());
	endtask

	// A register write is one request on the configuration channel; the predictor
	// takes the new value at the edge where the block takes it.
	task automatic write_register(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pec_pkg::CFG_START_SLOPE:   regs.start_slope = value[11:0];
			pec_pkg::CFG_CONFIRM_SLOPE: regs.confirm_slope = value[11:0];
			pec_pkg::CFG_FALL_SLOPE:    regs.fall_slope = value[12:0];
			pec_pkg::CFG_POWER_HIGH:    regs.power_high_mw = value;
			pec_pkg::CFG_WARMUP_END:    regs.warmup_end_ms = value;
			pec_pkg::CFG_LONG_PUFF:     regs.long_puff_after_ms = value;
			pec_pkg::CFG_WARM_DROP:     regs.warm_drop_centi = value;
			pec_pkg::CFG_SESSION_PUFFS: regs.session_puffs = value[5:0];
			default: ;
		endcase
	endtask

	// Writes every register, with junk in the unused upper data bits, plus one write
	// to an index past the last register that must change nothing.
	task automatic load_settings(input pec_pkg::cfg_t c);
		write_register(pec_pkg::CFG_START_SLOPE, {4'($urandom), c.start_slope});
		write_register(pec_pkg::CFG_CONFIRM_SLOPE, {4'($urandom), c.confirm_slope});
		write_register(pec_pkg::CFG_FALL_SLOPE, {3'($urandom), c.fall_slope});
		write_register(pec_pkg::CFG_POWER_HIGH, c.power_high_mw);
		write_register(IDX_W'($urandom_range(int'(pec_pkg::CFG_SESSION_PUFFS) + 1,
			(1 << IDX_W) - 1)), 16'($urandom));
		write_register(pec_pkg::CFG_WARMUP_END, c.warmup_end_ms);
		write_register(pec_pkg::CFG_LONG_PUFF, c.long_puff_after_ms);
		write_register(pec_pkg::CFG_WARM_DROP, c.warm_drop_centi);
		write_register(pec_pkg::CFG_SESSION_PUFFS, {10'($urandom), c.session_puffs});
		cfg_valid <= 1'b0;
	endtask

	function automatic pec_pkg::cfg_t typical_settings();
		logic [11:0] start;
		start = 12'($urandom_range(20, 150));
		return pack_settings(start, start + 12'($urandom_range(0, 60)),
			13'(10 - int'($urandom_range(0, 70))), 16'($urandom_range(500, 6000)),
			16'($urandom_range(0, 20000)), 16'($urandom_range(0, 40000)),
			16'($urandom_range(0, 2000)), 6'($urandom_range(1, 63)));
	endfunction

	// Waits until every request has gone in and every predicted result has come out.
	task automatic drain_results();
		while (samples_to_send.size() != 0 || sample_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed puff shapes after warm-up, with power stretches, warm-up
	// sessions, restarts and fully random requests mixed in.
	task automatic run_random_phase(input int unsigned amount);
		int unsigned stop_at, rise, flat, fall, count;
		int          step;
		logic [15:0] temp;
		logic [31:0] ms;
		stop_at = queued_count + amount;
		while (queued_count < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					ms = {16'd0, regs.warmup_end_ms} + 32'd1 + $urandom_range(0, 40000);
					temp = 16'($urandom_range(12000, 40000));
					rise = $urandom_range(1, 4);
					flat = $urandom_range(0, 14);
					fall = $urandom_range(1, 4);
					for (int unsigned i = 0; i < rise + flat + fall; i++) begin
						if (i < rise)
							step = ($urandom_range(3) == 0) ? $urandom_range(5, 900)
								: $urandom_range(5, 60);
						else if (i < rise + flat)
							step = int'($urandom_range(0, 6)) - 3;
						else
							step = -int'($urandom_range(5, 120));
						temp = temp + 16'(step);
						push_sample(pec_pkg::FUNC_TEMP, temp, 16'($urandom), ms);
						ms = ms + $urandom_range(20, 120);
					end
				end
				5: push_power_stretch(($urandom_range(7) == 0) ? $urandom_range(0, 400)
					: $urandom_range(0, 40));
				6: begin
					// A fresh session so that the warm-up curve test applies again.
					push_sample(pec_pkg::FUNC_RESTART, 16'($urandom), 16'($urandom), $urandom);
					count = $urandom_range(2, 8);
					for (int unsigned i = 0; i < count; i++) begin
						ms = $urandom_range(1) ? $urandom_range(5990, 6010)
							: $urandom_range(0, int'(regs.warmup_end_ms));
						if (ms > {16'd0, regs.warmup_end_ms}) ms = {16'd0, regs.warmup_end_ms};
						push_sample(pec_pkg::FUNC_TEMP, 16'($urandom_range(0, 40000)),
							16'($urandom), ms);
					end
				end
				7, 8: push_sample(2'($urandom), 16'($urandom), 16'($urandom), $urandom);
				default: push_sample(pec_pkg::FUNC_RESTART, 16'($urandom), 16'($urandom),
					$urandom);
			endcase
		end
	endtask

	// Driver: a request stays on the bus until the block takes it; the predictor
	// runs at the edge of acceptance.
	always @(posedge clk) begin
		logic go_idle;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				results_due.push_back(predict_sample(sample));
				accepted_count++;
			end
			if (!sample_valid || !sample_stall) begin
				go_idle = !steady && ($urandom_range(99) < 6);
				if (samples_to_send.size() != 0 && !go_idle) begin
					sample <= samples_to_send.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result is checked field by field against the oldest
	// prediction.
	always @(posedge clk) begin
		pec_pkg::result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					report($sformatf("result %h arrived with nothing outstanding", result));
				end else begin
					want = results_due.pop_front();
					if (result.puffs_left !== want.puffs_left)
						report($sformatf("puffs_left is %0d, predicted %0d",
							result.puffs_left, want.puffs_left));
					if (result.slope_x200 !== want.slope_x200)
						report($sformatf("slope_x200 is %0d, predicted %0d",
							result.slope_x200, want.slope_x200));
					if (result.detect_phase !== want.detect_phase)
						report($sformatf("detect_phase is %0d, predicted %0d",
							result.detect_phase, want.detect_phase));
					if (result.puffs_taken !== want.puffs_taken)
						report($sformatf("puffs_taken is %0d, predicted %0d",
							result.puffs_taken, want.puffs_taken));
				end
			end
			result_stall <= (hold_left != 0) || (!steady && $urandom_range(99) < 6);
		end
	end

	// One long hold-off on the result side, started once enough requests have gone in.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && hold_at != 0 && accepted_count >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		pec_pkg::cfg_t c;
		regs = pack_settings(12'd70, 12'd84, -13'sd10, 16'd3000, 16'd10000, 16'd25000,
			16'd800, 6'd15);
		seen_temp[0] = '0;
		seen_temp[1] = '0;
		det_phase = pec_pkg::PH_IDLE;
		det_timer = '0;
		puffs_now = regs.session_puffs;
		hot_ticks = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset settings.
		push_sample(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		push_sample(pec_pkg::FUNC_POWER, 16'd0, 16'hFFFF, 32'd5000);    // too early, ignored
		push_sample(pec_pkg::FUNC_POWER, 16'd0, 16'hFFFF, 32'd5001);
		push_sample(pec_pkg::FUNC_POWER, 16'hFFFF, 16'd0, 32'd5001);    // short stretch
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'd0);
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'd6000);       // window not open yet
		push_sample(pec_pkg::FUNC_TEMP, 16'hFFFF, 16'd0, 32'd7000);
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'd6001);       // far below the curve
		push_sample(pec_pkg::FUNC_RESTART, 16'd0, 16'd0, 32'd0);
		push_sample(pec_pkg::FUNC_TEMP, 16'd30000, 16'd0, 32'd8000);
		push_sample(pec_pkg::FUNC_RESTART, 16'd0, 16'd0, 32'd0);
		push_sample(pec_pkg::FUNC_TEMP, 16'd31700, 16'd0, 32'd9000);   // exactly on the margin
		push_sample(pec_pkg::FUNC_TEMP, 16'd31699, 16'd0, 32'd9000);   // one below it
		push_sample(pec_pkg::FUNC_RESTART, 16'd0, 16'd0, 32'd0);
		push_sample(pec_pkg::FUNC_TEMP, 16'd20000, 16'd0, 32'd10000);  // last warm-up instant
		// A clean rise, confirm, fall sequence.
		push_sample(pec_pkg::FUNC_TEMP, 16'd20020, 16'd0, 32'd10001);
		push_sample(pec_pkg::FUNC_TEMP, 16'd20040, 16'd0, 32'd10021);
		push_sample(pec_pkg::FUNC_TEMP, 16'd20060, 16'd0, 32'd10041);
		push_sample(pec_pkg::FUNC_TEMP, 16'd20000, 16'd0, 32'd10061);
		// Extreme slopes, then the confirm state running out of time.
		push_sample(pec_pkg::FUNC_TEMP, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'hFFFF_FFFF);
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'hFFFF_FFFF);
		push_sample(pec_pkg::FUNC_TEMP, 16'd0, 16'd0, 32'hFFFF_FFFF);
		push_sample(pec_pkg::FUNC_RESTART, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		drain_results();

		// Random traffic under several settings, the extremes among them.
		load_settings(typical_settings());
		run_random_phase(90);
		drain_results();
		load_settings(pack_settings(12'd0, 12'd0, -13'sd4096, 16'd0, 16'd0, 16'd0, 16'd0,
			6'd1));
		run_random_phase(90);
		drain_results();
		load_settings(pack_settings(12'd4095, 12'd4095, 13'sd4095, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 6'd63));
		run_random_phase(90);
		drain_results();
		load_settings(pack_settings(12'($urandom), 12'($urandom), 13'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			6'($urandom_range(1, 63))));
		run_random_phase(90);
		drain_results();
		// Long warm-up so the curve is reached past its last breakpoint.
		c = typical_settings();
		c.warmup_end_ms = 16'hFFFF;
		load_settings(c);
		run_random_phase(90);
		drain_results();

		// Power stretches on both sides of the one-puff threshold. No idling here; the
		// long hold-off lands early on while the sender keeps offering requests.
		load_settings(pack_settings(12'd70, 12'd84, -13'sd10, 16'd3000, 16'd10000,
			16'd25000, 16'd800, 6'd15));
		steady = 1'b1;
		hold_at = accepted_count + 100;
		push_sample(pec_pkg::FUNC_RESTART, 16'($urandom), 16'($urandom), $urandom);
		push_power_stretch(pec_pkg::TICKS_FOR_1 - 1);
		push_sample(pec_pkg::FUNC_RESTART, 16'($urandom), 16'($urandom), $urandom);
		push_power_stretch(pec_pkg::TICKS_FOR_1);
		drain_results();
		steady = 1'b0;

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ puff_event_counter.f @@
+incdir+hw/rtl
hw/rtl/pec_pkg.sv
hw/rtl/pec_cfg.sv
hw/rtl/pec_curve.sv
hw/rtl/pec_core.sv
hw/rtl/puff_event_counter.sv
sim/testbench.sv
